// ===== src/pswd_pkg.sv =====
// shared types, constants and byte tables of the stored-deflate png writer
// no dependencies
package pswd_pkg;

   localparam int MAX_WIDTH_DEF   = 4096;
   localparam int MAX_HEIGHT_DEF  = 4096;
   localparam int BLOCK_BYTES_DEF = 65535;
   localparam int QUEUE_DEPTH     = 4;
   localparam int CFG_W           = 13;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;
   localparam logic [16:0] ADLER_MOD = 17'd65521;

   // byte positions inside the file header and the trailer
   localparam logic [5:0] HDR_IHDR_TAG = 6'd12;
   localparam logic [5:0] HDR_IHDR_CRC = 6'd29;
   localparam logic [5:0] HDR_IDAT_LEN = 6'd33;
   localparam logic [5:0] HDR_IDAT_TAG = 6'd37;
   localparam logic [5:0] HDR_LAST     = 6'd42;
   localparam logic [5:0] TRL_CRC      = 6'd4;
   localparam logic [5:0] TRL_IEND     = 6'd8;
   localparam logic [5:0] TRL_LAST     = 6'd19;
   localparam logic [2:0] RAW_ALPHA    = 3'd4;
   localparam logic [5:0] CALL_LIMIT   = 6'd53;

   // register indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_HDR  = 5'b00010,
      ST_BHDR = 5'b00100,
      ST_RAW  = 5'b01000,
      ST_TRL  = 5'b10000
   } state_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   // fixed bytes of the header, variable positions read as zero
   function automatic logic [7:0] hdr_const(input logic [5:0] idx);
      logic [7:0] v;
      case (idx)
         6'd0:    v = 8'h89;
         6'd1:    v = 8'h50;
         6'd2:    v = 8'h4E;
         6'd3:    v = 8'h47;
         6'd4:    v = 8'h0D;
         6'd5:    v = 8'h0A;
         6'd6:    v = 8'h1A;
         6'd7:    v = 8'h0A;
         6'd11:   v = 8'h0D;
         6'd12:   v = 8'h49;
         6'd13:   v = 8'h48;
         6'd14:   v = 8'h44;
         6'd15:   v = 8'h52;
         6'd24:   v = 8'h08;
         6'd25:   v = 8'h06;
         6'd37:   v = 8'h49;
         6'd38:   v = 8'h44;
         6'd39:   v = 8'h41;
         6'd40:   v = 8'h54;
         6'd41:   v = 8'h78;
         6'd42:   v = 8'h01;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // iend chunk, trailer positions 8 to 19
   function automatic logic [7:0] iend_byte(input logic [5:0] idx);
      logic [7:0] v;
      case (idx)
         6'd12:   v = 8'h49;
         6'd13:   v = 8'h45;
         6'd14:   v = 8'h4E;
         6'd15:   v = 8'h44;
         6'd16:   v = 8'hAE;
         6'd17:   v = 8'h42;
         6'd18:   v = 8'h60;
         6'd19:   v = 8'h82;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

// ===== src/pswd_front.sv =====
// front end: pixel intake queue between the stream input and the byte engine
// depends on pswd_pkg
module pswd_front
   import pswd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  pixel_type in_pixel,
   output logic      out_valid,
   input  logic      out_ready,
   output pixel_type out_pixel
);
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   pixel_type         mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              push, pop;

   assign in_ready  = (cnt_ff != CW'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_pixel = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? PW'(wr_ff + PW'(1)) : wr_ff;
      rd_in  = pop ? PW'(rd_ff + PW'(1)) : rd_ff;
      cnt_in = CW'(cnt_ff + CW'(push) - CW'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_pixel;
      end
   end
endmodule

// ===== src/pswd_back.sv =====
// back end: byte engine that sequences header, block headers, raw bytes and trailer
// depends on pswd_pkg
module pswd_back
   import pswd_pkg::*;
#(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CFG_W-1:0] cfg_width,
   input  logic [CFG_W-1:0] cfg_height,
   input  logic             q_valid,
   output logic             q_ready,
   input  pixel_type        q_pixel,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser
);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int RAW_W = $clog2(MAX_HEIGHT * (4 * MAX_WIDTH + 1) + 1);
   localparam int NUM_W = RAW_W + 1;
   // reciprocal of the block size, exact for every numerator below 2**NUM_W
   localparam int SH    = NUM_W + $clog2(BLOCK_BYTES);
   localparam logic [NUM_W:0] RECIP =
      (NUM_W+1)'(((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));

   state_type         st_ff, st_in;
   logic [5:0]        idx_ff, idx_in;
   logic [2:0]        rsel_ff, rsel_in;
   logic [5:0]        call_ff, call_in;
   logic              hold_ff, hold_in;
   logic              hdr_done_ff, hdr_done_in;
   logic [WW-1:0]     fw_ff, fw_in, col_ff, col_in;
   logic [HW-1:0]     fh_ff, fh_in, row_ff, row_in;
   pixel_type         px_ff, px_in;
   logic [15:0]       alo_ff, alo_in, ahi_ff, ahi_in;
   logic [31:0]       crc_ff, crc_in;
   logic [15:0]       blk_ff, blk_in;
   logic [RAW_W-1:0]  rleft_ff, rleft_in;
   logic              ov_ff, ov_in, ol_ff, ol_in, oe_ff, oe_in;
   logic [7:0]        ob_ff, ob_in;

   // size product and block count
   logic              mul_go_ff, mul_go_in;
   logic              dload_ff;
   logic              dmul_ff;
   logic              lgo_ff, lok_ff, lok_in;
   logic [RAW_W-1:0]  raw_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [NUM_W-1:0]  dq_ff;
   logic [2*NUM_W:0]  prod;
   logic [31:0]       len_ff;

   logic [7:0]        bval;
   logic              want, fire, covered, restart, last_px, eof, pop;
   logic [15:0]       bn;
   logic [WW-1:0]     cw;
   logic [HW-1:0]     ch;
   logic [31:0]       w32, h32;
   logic [16:0]       lo_s, lo_n, hi_s, hi_n;

   // clamp of the size registers
   always_comb begin
      if (cfg_width == '0) begin
         cw = WW'(1);
      end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
         cw = WW'(MAX_WIDTH);
      end else begin
         cw = WW'(cfg_width);
      end
      if (cfg_height == '0) begin
         ch = HW'(1);
      end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
         ch = HW'(MAX_HEIGHT);
      end else begin
         ch = HW'(cfg_height);
      end
   end

   assign w32 = 32'(fw_ff);
   assign h32 = 32'(fh_ff);
   assign bn  = (rleft_ff < RAW_W'(BLOCK_BYTES)) ? 16'(rleft_ff) : 16'(BLOCK_BYTES);
   assign eof = (col_ff == WW'(fw_ff - WW'(1))) && (row_ff == HW'(fh_ff - HW'(1)));

   // byte selection
   always_comb begin
      bval    = 8'h00;
      want    = 1'b0;
      covered = 1'b0;
      restart = 1'b0;
      last_px = 1'b0;
      case (st_ff)
         ST_HDR: begin
            want = (idx_ff < HDR_IDAT_LEN) || (idx_ff >= HDR_IDAT_TAG) || lok_ff;
            covered = ((idx_ff >= HDR_IHDR_TAG) && (idx_ff < HDR_IHDR_CRC)) ||
                      (idx_ff >= HDR_IDAT_TAG);
            restart = (idx_ff == HDR_IHDR_TAG) || (idx_ff == HDR_IDAT_TAG);
            case (idx_ff)
               6'd16:   bval = w32[31:24];
               6'd17:   bval = w32[23:16];
               6'd18:   bval = w32[15:8];
               6'd19:   bval = w32[7:0];
               6'd20:   bval = h32[31:24];
               6'd21:   bval = h32[23:16];
               6'd22:   bval = h32[15:8];
               6'd23:   bval = h32[7:0];
               6'd29:   bval = ~crc_ff[31:24];
               6'd30:   bval = ~crc_ff[23:16];
               6'd31:   bval = ~crc_ff[15:8];
               6'd32:   bval = ~crc_ff[7:0];
               6'd33:   bval = len_ff[31:24];
               6'd34:   bval = len_ff[23:16];
               6'd35:   bval = len_ff[15:8];
               6'd36:   bval = len_ff[7:0];
               default: bval = hdr_const(idx_ff);
            endcase
         end
         ST_BHDR: begin
            want    = 1'b1;
            covered = 1'b1;
            case (idx_ff)
               6'd0:    bval = {7'd0, (rleft_ff <= RAW_W'(BLOCK_BYTES))};
               6'd1:    bval = bn[7:0];
               6'd2:    bval = bn[15:8];
               6'd3:    bval = ~bn[7:0];
               default: bval = ~bn[15:8];
            endcase
         end
         ST_RAW: begin
            want    = (blk_ff != '0);
            covered = 1'b1;
            last_px = (rsel_ff == RAW_ALPHA) && !eof;
            case (rsel_ff)
               3'd1:    bval = px_ff.red;
               3'd2:    bval = px_ff.green;
               3'd3:    bval = px_ff.blue;
               3'd4:    bval = px_ff.alpha;
               default: bval = 8'h00;
            endcase
         end
         ST_TRL: begin
            want    = 1'b1;
            covered = (idx_ff < TRL_CRC);
            last_px = (idx_ff == TRL_LAST);
            case (idx_ff)
               6'd0:    bval = ahi_ff[15:8];
               6'd1:    bval = ahi_ff[7:0];
               6'd2:    bval = alo_ff[15:8];
               6'd3:    bval = alo_ff[7:0];
               6'd4:    bval = ~crc_ff[31:24];
               6'd5:    bval = ~crc_ff[23:16];
               6'd6:    bval = ~crc_ff[15:8];
               6'd7:    bval = ~crc_ff[7:0];
               default: bval = iend_byte(idx_ff);
            endcase
         end
         default: begin
            want = 1'b0;
         end
      endcase
   end

   assign fire    = want && !hold_ff && (!ov_ff || rsp_tready);
   assign q_ready = (st_ff == ST_IDLE) || hold_ff;
   assign pop     = q_valid && q_ready;

   // adler sums
   always_comb begin
      lo_s = 17'(alo_ff) + 17'(bval);
      lo_n = (lo_s >= ADLER_MOD) ? 17'(lo_s - ADLER_MOD) : lo_s;
      hi_s = 17'(ahi_ff) + lo_n;
      hi_n = (hi_s >= ADLER_MOD) ? 17'(hi_s - ADLER_MOD) : hi_s;
   end

   always_comb begin
      st_in       = st_ff;
      idx_in      = idx_ff;
      rsel_in     = rsel_ff;
      call_in     = call_ff;
      hold_in     = hold_ff;
      hdr_done_in = hdr_done_ff;
      fw_in       = fw_ff;
      fh_in       = fh_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      px_in       = px_ff;
      alo_in      = alo_ff;
      ahi_in      = ahi_ff;
      crc_in      = crc_ff;
      blk_in      = blk_ff;
      rleft_in    = rleft_ff;
      mul_go_in   = 1'b0;
      lok_in      = lgo_ff ? 1'b1 : lok_ff;
      ov_in       = (ov_ff && !rsp_tready) ? 1'b1 : 1'b0;
      ob_in       = ob_ff;
      ol_in       = ol_ff;
      oe_in       = oe_ff;

      if (pop) begin
         call_in = '0;
         if (hold_ff) begin
            // held bytes resume, this pixel is dropped
            hold_in = 1'b0;
         end else begin
            px_in = q_pixel;
            if (!hdr_done_ff) begin
               fw_in     = cw;
               fh_in     = ch;
               st_in     = ST_HDR;
               idx_in    = '0;
               mul_go_in = 1'b1;
               lok_in    = 1'b0;
            end else begin
               st_in   = ST_RAW;
               rsel_in = (col_ff == '0) ? 3'd0 : 3'd1;
            end
         end
      end

      if ((st_ff == ST_RAW) && (blk_ff == '0)) begin
         st_in  = ST_BHDR;
         idx_in = '0;
      end

      if (fire) begin
         ov_in   = 1'b1;
         ob_in   = bval;
         oe_in   = (st_ff == ST_TRL) && (idx_ff == TRL_LAST);
         ol_in   = last_px || (call_ff == CALL_LIMIT - 6'd1);
         call_in = 6'(call_ff + 6'd1);
         if (!last_px && (call_ff == CALL_LIMIT - 6'd1)) begin
            hold_in = 1'b1;
         end
         if (covered) begin
            crc_in = crc_byte(restart ? ALL_ONES : crc_ff, bval);
         end
         case (st_ff)
            ST_HDR: begin
               if (idx_ff == HDR_LAST) begin
                  st_in       = ST_RAW;
                  rsel_in     = '0;
                  rleft_in    = raw_ff;
                  blk_in      = '0;
                  hdr_done_in = 1'b1;
                  alo_in      = 16'd1;
                  ahi_in      = 16'd0;
                  col_in      = '0;
                  row_in      = '0;
               end else begin
                  idx_in = 6'(idx_ff + 6'd1);
               end
            end
            ST_BHDR: begin
               if (idx_ff == 6'd4) begin
                  st_in  = ST_RAW;
                  blk_in = bn;
               end else begin
                  idx_in = 6'(idx_ff + 6'd1);
               end
            end
            ST_RAW: begin
               alo_in   = lo_n[15:0];
               ahi_in   = hi_n[15:0];
               blk_in   = 16'(blk_ff - 16'd1);
               rleft_in = (rleft_ff != '0) ? RAW_W'(rleft_ff - RAW_W'(1)) : rleft_ff;
               if (rsel_ff == RAW_ALPHA) begin
                  if (col_ff == WW'(fw_ff - WW'(1))) begin
                     col_in = '0;
                     row_in = HW'(row_ff + HW'(1));
                  end else begin
                     col_in = WW'(col_ff + WW'(1));
                  end
                  if (eof) begin
                     st_in  = ST_TRL;
                     idx_in = '0;
                  end else begin
                     st_in = ST_IDLE;
                  end
               end else begin
                  rsel_in = 3'(rsel_ff + 3'd1);
               end
            end
            ST_TRL: begin
               if (idx_ff == TRL_LAST) begin
                  st_in       = ST_IDLE;
                  hdr_done_in = 1'b0;
                  col_in      = '0;
                  row_in      = '0;
                  blk_in      = '0;
                  rleft_in    = '0;
                  alo_in      = 16'd1;
                  ahi_in      = 16'd0;
                  crc_in      = ALL_ONES;
               end else begin
                  idx_in = 6'(idx_ff + 6'd1);
               end
            end
            default: begin
               st_in = st_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         idx_ff      <= '0;
         rsel_ff     <= '0;
         call_ff     <= '0;
         hold_ff     <= 1'b0;
         hdr_done_ff <= 1'b0;
         fw_ff       <= WW'(1);
         fh_ff       <= HW'(1);
         col_ff      <= '0;
         row_ff      <= '0;
         alo_ff      <= 16'd1;
         ahi_ff      <= 16'd0;
         crc_ff      <= ALL_ONES;
         blk_ff      <= '0;
         rleft_ff    <= '0;
         ov_ff       <= 1'b0;
         mul_go_ff   <= 1'b0;
         lok_ff      <= 1'b0;
      end else begin
         st_ff       <= st_in;
         idx_ff      <= idx_in;
         rsel_ff     <= rsel_in;
         call_ff     <= call_in;
         hold_ff     <= hold_in;
         hdr_done_ff <= hdr_done_in;
         fw_ff       <= fw_in;
         fh_ff       <= fh_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         alo_ff      <= alo_in;
         ahi_ff      <= ahi_in;
         crc_ff      <= crc_in;
         blk_ff      <= blk_in;
         rleft_ff    <= rleft_in;
         ov_ff       <= ov_in;
         mul_go_ff   <= mul_go_in;
         lok_ff      <= lok_in;
      end
      px_ff <= px_in;
      ob_ff <= ob_in;
      ol_ff <= ol_in;
      oe_ff <= oe_in;
   end

   // raw size, rounded-up numerator, block count by reciprocal multiply, length
   assign prod = (2*NUM_W+1)'(num_ff) * (2*NUM_W+1)'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         dload_ff <= 1'b0;
         dmul_ff  <= 1'b0;
         lgo_ff   <= 1'b0;
      end else begin
         dload_ff <= mul_go_ff;
         dmul_ff  <= dload_ff;
         lgo_ff   <= dmul_ff;
      end
      if (mul_go_ff) begin
         raw_ff <= RAW_W'(RAW_W'(fh_ff) * RAW_W'({fw_ff, 2'b01}));
      end
      if (dload_ff) begin
         num_ff <= NUM_W'(NUM_W'(raw_ff) + NUM_W'(BLOCK_BYTES - 1));
      end
      if (dmul_ff) begin
         dq_ff <= NUM_W'(prod >> SH);
      end
      if (lgo_ff) begin
         len_ff <= 32'd6 + 32'(raw_ff) + (32'(dq_ff) << 2) + 32'(dq_ff);
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = ob_ff;
   assign rsp_tlast  = ol_ff;
   assign rsp_tuser  = oe_ff;
endmodule

// ===== src/png_stored_deflate_writer.sv =====
// top level of the stored-deflate rgba8 png writer
// depends on pswd_pkg, pswd_front and pswd_back
//
// usage:
//  - req channel: one rgba8 pixel per transaction, raster order
//  - rsp channel: the png file, one byte per transaction; tlast marks the
//    last byte caused by a pixel, tuser marks the last byte of the file
//  - csr port: register 0 image width (addr 0), register 1 image height
//    (addr 4); the size is taken at the first pixel of each file
//  - the first pixel of a file emits signature, ihdr, idat length and tag
//    and the zlib header (43 bytes) ahead of its pixel bytes; the last pixel
//    adds adler-32, idat crc and iend (20 bytes)
//  - a pixel gives at most 53 bytes; if it causes more, the rest waits and
//    goes out on the next pixel transaction, whose pixel is discarded
//  - throughput: one byte per cycle while rsp does not stall; a pixel gives its
//    4 bytes (a filter byte ahead at a row start) and leaves the queue once the
//    engine is idle; its bytes pass the pixel register and the output register
//  - the idat length waits on the raw size product and a reciprocal multiply
//    for the block count, registered as product, numerator, quotient and length,
//    hidden behind the first 33 header bytes
//  - a 4-entry pixel queue keeps req open while rsp stalls; a stall only
//    holds the byte engine, no byte is lost
//  - reset: synchronous, clears the queue, the engine and the size registers
//    to 1 x 1
module png_stored_deflate_writer
   import pswd_pkg::*;
#(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // pixel stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
   // byte stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte [7:0]
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // file_end [0]
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [CFG_W-1:0] width_ff, height_ff;
   logic             csr_wr;
   logic             q_valid, q_ready;
   pixel_type        q_pixel;

   // register file, write in the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_HEIGHT) ? 32'(height_ff) : 32'(width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(1);
         height_ff <= CFG_W'(1);
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_WIDTH) begin
            width_ff <= csr_pwdata[CFG_W-1:0];
         end else begin
            height_ff <= csr_pwdata[CFG_W-1:0];
         end
      end
   end

   // pixel intake queue
   pswd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pixel  (pixel_type'(req_tdata)),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_pixel (q_pixel)
   );

   // byte engine with the output register
   pswd_back #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_pixel    (q_pixel),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );
endmodule

// ===== src/pswd_checker.sv =====
// port-level checks of the png writer, bound to the top level
// depends on png_stored_deflate_writer
module pswd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser,
   input logic        csr_pready
);
   // the file end byte also closes its pixel
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("file end without tlast");

   // every file closes with the last iend crc byte
   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'h82)
      else $error("file end byte is not the iend crc tail");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid after reset");

   // a stalled byte holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled byte changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");
endmodule

bind png_stored_deflate_writer pswd_checker u_pswd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);

// ===== dv/tb.sv =====
// testbench for png_stored_deflate_writer: pixel stream in, png byte stream out
// depends on pswd_pkg and the writer rtl; holds its own byte-exact png predictor
module tb;
   import pswd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int BYTES_PER_TX = 53;      // most bytes one pixel transaction releases
   localparam int SIZE_MAX     = 4096;
   localparam int STORED_MAX   = 65535;   // bytes per stored deflate block
   localparam int ADLER_BASE   = 65521;
   localparam int DRAIN_CYCLES = 40;      // covers the header divider and the pipe
   localparam logic [2:0] ADDR_WIDTH  = 3'd0;
   localparam logic [2:0] ADDR_HEIGHT = 3'd4;

   typedef struct {
      bit [7:0] data;
      bit       last;
      bit       fend;
   } png_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // out_byte [7:0]
   logic        rsp_tlast;
   logic        rsp_tuser;        // file_end [0]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   png_stored_deflate_writer u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle rates in percent, changed per phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   // predictor state, a private copy of the writer's
   bit [12:0] size_reg_w = 13'd1, size_reg_h = 13'd1;
   int unsigned file_w = 1, file_h = 1;
   int unsigned adler_lo = 1, adler_hi = 0;
   bit [31:0]   idat_crc = '1;
   int unsigned col = 0, row = 0;
   int unsigned block_left = 0, raw_left = 0;
   bit          in_file = 1'b0;
   bit [8:0]    held_bytes[$];     // {file end, byte} not yet released
   png_byte_type png_bytes_due[$]; // bytes the writer still owes

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------
   function automatic bit [31:0] crc32_next(bit [31:0] c, bit [7:0] b);
      c ^= {24'd0, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
      return c;
   endfunction

   function automatic int unsigned clamp_dim(bit [12:0] v);
      if (v == 0) return 1;
      return (v > SIZE_MAX) ? SIZE_MAX : v;
   endfunction

   task automatic hold_byte(bit [7:0] b, bit fend = 1'b0);
      held_bytes.push_back({fend, b});
   endtask

   task automatic hold_word(bit [31:0] v);
      for (int i = 3; i >= 0; i--) hold_byte(v[8*i +: 8]);
   endtask

   // bytes of the idat chunk are covered by its running crc
   task automatic idat_byte(bit [7:0] b);
      idat_crc = crc32_next(idat_crc, b);
      hold_byte(b);
   endtask

   task automatic raw_byte(bit [7:0] b);
      int unsigned n;
      bit [15:0]   nn;
      // a new stored block opens: final flag, len, nlen
      if (block_left == 0) begin
         n  = (raw_left < STORED_MAX) ? raw_left : STORED_MAX;
         nn = ~n[15:0];
         idat_byte((n >= raw_left) ? 8'd1 : 8'd0);
         idat_byte(n[7:0]);
         idat_byte(n[15:8]);
         idat_byte(nn[7:0]);
         idat_byte(nn[15:8]);
         block_left = n;
      end
      idat_byte(b);
      adler_lo = (adler_lo + b) % ADLER_BASE;
      adler_hi = (adler_hi + adler_lo) % ADLER_BASE;
      if (block_left != 0) block_left--;
      if (raw_left != 0) raw_left--;
   endtask

   task automatic open_file();
      bit [7:0]    ihdr[17];
      bit [31:0]   hcrc;
      int unsigned raw, blocks;
      file_w = clamp_dim(size_reg_w);
      file_h = clamp_dim(size_reg_h);
      raw    = file_h * (1 + 4 * file_w);
      blocks = (raw + STORED_MAX - 1) / STORED_MAX;
      foreach (ihdr[i]) ihdr[i] = 8'h00;
      {ihdr[0], ihdr[1], ihdr[2], ihdr[3]} = 32'h49484452;
      {ihdr[4], ihdr[5], ihdr[6], ihdr[7]} = file_w;
      {ihdr[8], ihdr[9], ihdr[10], ihdr[11]} = file_h;
      ihdr[12] = 8'd8;   // bit depth
      ihdr[13] = 8'd6;   // rgba
      hold_word(32'h89504E47);
      hold_word(32'h0D0A1A0A);
      hold_word(32'd13);
      hcrc = '1;
      foreach (ihdr[i]) begin
         hold_byte(ihdr[i]);
         hcrc = crc32_next(hcrc, ihdr[i]);
      end
      hold_word(~hcrc);
      hold_word(2 + raw + 5 * blocks + 4);
      idat_crc = '1;
      idat_byte(8'h49); idat_byte(8'h44); idat_byte(8'h41); idat_byte(8'h54);
      idat_byte(8'h78); idat_byte(8'h01);   // zlib header
      adler_lo = 1; adler_hi = 0;
      raw_left = raw; block_left = 0;
      col = 0; row = 0;
      in_file = 1'b1;
   endtask

   task automatic close_file();
      bit [31:0] adler;
      bit [31:0] crc_out;
      adler = {adler_hi[15:0], adler_lo[15:0]};
      for (int i = 3; i >= 0; i--) idat_byte(adler[8*i +: 8]);
      crc_out = ~idat_crc;
      hold_word(crc_out);
      hold_word(32'd0);
      hold_word(32'h49454E44);
      hold_word(32'hAE426082);
      held_bytes[$][8] = 1'b1;   // file end flag on the last iend byte
      in_file = 1'b0;
      col = 0; row = 0; block_left = 0; raw_left = 0;
      adler_lo = 1; adler_hi = 0; idat_crc = '1;
   endtask

   // one accepted pixel: update the state, release held bytes as due
   task automatic predict_png_bytes(bit [31:0] px);
      bit [8:0]     hb;
      png_byte_type e;
      int           n;
      // while bytes are held the pixel is dropped
      if (held_bytes.size() == 0) begin
         if (!in_file) open_file();
         if (col == 0) raw_byte(8'h00);   // filter type none
         for (int i = 0; i < 4; i++) raw_byte(px[8*i +: 8]);
         col++;
         if (col >= file_w) begin
            col = 0;
            row++;
            if (row >= file_h) close_file();
         end
      end
      n = 0;
      while (held_bytes.size() > 0 && n < BYTES_PER_TX) begin
         hb = held_bytes.pop_front();
         e.data = hb[7:0];
         e.last = 1'b0;
         e.fend = hb[8];
         png_bytes_due.push_back(e);
         n++;
      end
      if (n > 0) png_bytes_due[png_bytes_due.size() - 1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // checking and byte sink
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // receiver stalls at the phase's rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // signals are stable at the falling edge; a byte seen here is taken at the next rise
   always @(negedge clock) begin
      png_byte_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (png_bytes_due.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_tdata));
         end else begin
            e = png_bytes_due.pop_front();
            if (rsp_tdata !== e.data)
               report_mismatch($sformatf("byte %02h, want %02h", rsp_tdata, e.data));
            if (rsp_tlast !== e.last)
               report_mismatch($sformatf("tlast %b, want %b", rsp_tlast, e.last));
            if (rsp_tuser !== e.fend)
               report_mismatch($sformatf("file end %b, want %b", rsp_tuser, e.fend));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers, all entered and left at a rising edge
   // ---------------------------------------------------------------------------
   // one pixel transaction; valid stays high afterwards unless stop_pixels follows
   task automatic send_pixel(bit [31:0] px);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
      predict_png_bytes(px);
   endtask

   task automatic stop_pixels();
      req_tvalid <= 1'b0;
   endtask

   // sender holds off until every owed byte is out
   task automatic wait_drained();
      stop_pixels();
      while (png_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write then read back
   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == ADDR_WIDTH) size_reg_w = value[12:0];
      else size_reg_h = value[12:0];
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata !== {19'd0, value[12:0]})
         report_mismatch($sformatf("csr %0d reads %h", addr, csr_prdata));
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_size(logic [31:0] w, logic [31:0] h);
      csr_write(ADDR_WIDTH, w);
      csr_write(ADDR_HEIGHT, h);
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------
   // 1 x 1 file overflows one transaction; the next pixel only flushes the rest
   task automatic test_tiny_file();
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      wait_drained();
      set_size(32'h0, 32'hFFFF_E000);   // zero counts as one, upper bits dropped
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h1234_5678);
      wait_drained();
   endtask

   // bit patterns plus a size write in the middle of a file
   task automatic test_patterns_midfile();
      bit [31:0] pat[6] = '{32'hAAAA_5555, 32'h5555_AAAA, 32'h0102_0408,
                           32'h1020_4080, 32'hFF00_FF00, 32'h00FF_00FF};
      set_size(32'd3, 32'd2);
      send_pixel(pat[0]);
      send_pixel(pat[1]);
      wait_drained();
      csr_write(ADDR_WIDTH, 32'd5);   // only the next file sees it
      for (int i = 2; i < 6; i++) send_pixel(pat[i]);
      for (int i = 0; i < 10; i++) send_pixel(~pat[i % 6]);
      wait_drained();
   endtask

   // small random images, random content
   task automatic test_random_images(int n_pixels);
      int sent;
      int w, h;
      sent = 0;
      while (sent < n_pixels) begin
         w = $urandom_range(0, 9);
         h = $urandom_range(0, 5);
         set_size(w, h);
         w = (w == 0) ? 1 : w;
         h = (h == 0) ? 1 : h;
         for (int i = 0; i < w * h; i++) send_pixel($urandom);
         // a 1 x 1 file leaves bytes held: one more pixel releases them
         if (w * h == 1) send_pixel($urandom);
         sent += w * h;
         wait_drained();
      end
   endtask

   // sizes above the maximum clamp to it; such an image spans many stored
   // blocks, so its first block header is not final; the file stays open
   task automatic test_size_clamp();
      set_size(32'd8191, 32'd8191);
      for (int i = 0; i < 24; i++) send_pixel($urandom);
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles rarely, receiver often
      send_idle_pct = 8;
      recv_idle_pct = 65;
      test_tiny_file();
      test_patterns_midfile();
      test_random_images(70);

      // the other way round
      send_idle_pct = 65;
      recv_idle_pct = 8;
      test_random_images(70);

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_images(70);
      test_size_clamp();

      stop_pixels();
      while (png_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/pswd_pkg.sv
src/pswd_front.sv
src/pswd_back.sv
src/png_stored_deflate_writer.sv
src/pswd_checker.sv
dv/tb.sv
